// ===== design/dvt_pkg.sv =====
// shared types and constants for the distinct value tracker
// no dependencies; imported by every module of the block
package dvt_pkg;

  localparam int SLOTS_DEF   = 1024;
  localparam int VALUES_DEF  = 1024;
  localparam int SLOT_W      = 10;
  localparam int VALUE_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // one classified assignment on its way from front to back
  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } item_t;

endpackage

// ===== design/distinct_value_tracker_top.sv =====
// top level of the distinct value tracker: front, queue and back joined
// depends on dvt_pkg, dvt_front, dvt_queue and dvt_back

// Each beat assigns new_value to slot_index and returns how many distinct
// nonzero values are held by any slot afterwards; value zero releases the
// slot, and a beat whose slot or value is out of range changes nothing but
// still returns the current count. After reset a clearing pass zeroes both
// tables, one entry per cycle over max(SLOTS, VALUES) entries, while s_tready
// stays low. Each item passes through the back end as slot read, tally read,
// old tally write and new tally write; for items that follow closely, the
// slot read of the next item shares a cycle with the last tally write, which
// waits while the result register is still full. The single write port of the
// tally table keeps the two tally writes in separate steps.
module distinct_value_tracker_top #(
  parameter int SLOTS  = dvt_pkg::SLOTS_DEF,
  parameter int VALUES = dvt_pkg::VALUES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot_index [9:0], new_value [19:10], zero [23:20]
  input  logic [dvt_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // distinct_count [10:0], zero [15:11]
  output logic [dvt_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import dvt_pkg::*;

  logic  clearing;
  logic  push;
  item_t push_item;
  logic  q_ready;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  dvt_front #(.SLOTS(SLOTS), .VALUES(VALUES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  dvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  dvt_back #(.SLOTS(SLOTS), .VALUES(VALUES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // no beat gets in while the tables are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(s_tvalid && s_tready))
    else $error("input beat accepted during clearing pass");

  // the count can never pass the number of usable values or of slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[COUNT_W-1:0]) < 32'(VALUES)) &&
                 (32'(m_tdata[COUNT_W-1:0]) <= 32'(SLOTS)))
    else $error("distinct count out of range");

  // the back end takes nothing from the queue while the clearing pass runs
  a_queue_empty_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !pop)
    else $error("back end popped an item during clearing");

endmodule

// ===== design/dvt_front.sv =====
// input side: takes beats from the stream, range-checks them and holds one
// classified item for the queue; uses dvt_pkg
module dvt_front #(
  parameter int SLOTS  = dvt_pkg::SLOTS_DEF,
  parameter int VALUES = dvt_pkg::VALUES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clearing,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dvt_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             push,
  output dvt_pkg::item_t                   push_item,
  input  logic                             q_ready
);
  import dvt_pkg::*;

  logic              hold_v;
  item_t             hold;
  logic [SLOT_W-1:0] in_slot;
  logic [VALUE_W-1:0] in_value;
  logic              in_ok;

  assign in_slot  = s_tdata[SLOT_W-1:0];
  assign in_value = s_tdata[SLOT_W+VALUE_W-1:SLOT_W];
  // out-of-range items still give a result, but touch no table
  assign in_ok = (32'(in_slot) < 32'(SLOTS)) && (32'(in_value) < 32'(VALUES));

  assign s_tready  = !clearing && (!hold_v || q_ready);
  assign push      = hold_v && q_ready;
  assign push_item = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_v <= 1'b1;
    end else if (push) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold <= '{ok: in_ok, slot: in_slot, value: in_value};
    end
  end

endmodule

// ===== design/dvt_queue.sv =====
// two-entry queue between front and back so either side can stall alone
// uses dvt_pkg for the item type
module dvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dvt_pkg::item_t push_item,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output dvt_pkg::item_t q_item
);
  import dvt_pkg::*;

  localparam int DEPTH = 2;

  item_t      entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_ready = (count != 2'(DEPTH));
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/dvt_back.sv =====
// execution side: slot table, tally table, distinct total and result register
// also runs the clearing pass after reset; uses dvt_pkg
module dvt_back #(
  parameter int SLOTS  = dvt_pkg::SLOTS_DEF,
  parameter int VALUES = dvt_pkg::VALUES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  output logic                            clearing,
  input  logic                            q_valid,
  input  dvt_pkg::item_t                  q_item,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dvt_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import dvt_pkg::*;

  localparam int SAW       = $clog2(SLOTS);
  localparam int VAW       = $clog2(VALUES);
  localparam int CLR_DEPTH = (SLOTS > VALUES) ? SLOTS : VALUES;
  localparam int CAW       = $clog2(CLR_DEPTH);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_TALLY  = 3'd2;
  localparam logic [2:0] ST_WR_OLD = 3'd3;
  localparam logic [2:0] ST_WR_NEW = 3'd4;

  logic [VALUE_W-1:0] slot_mem  [SLOTS];
  logic [COUNT_W-1:0] tally_mem [VALUES];

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CAW-1:0]     clr_addr;
  item_t              cur;
  logic [VALUE_W-1:0] slot_rd;
  logic [COUNT_W-1:0] tally_old;
  logic [COUNT_W-1:0] tally_new;
  logic               rel;
  logic               clm;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] total_next;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic               advance;

  logic               slot_we;
  logic [SAW-1:0]     slot_wa;
  logic [VALUE_W-1:0] slot_wd;
  logic               tally_we;
  logic [VAW-1:0]     tally_wa;
  logic [COUNT_W-1:0] tally_wd;

  assign clearing = (state == ST_CLEAR);
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_count);

  // last step may hand off its result only when the output register frees up
  assign advance = (state == ST_WR_NEW) && (!out_valid || m_tready);
  // next slot read overlaps the final tally write of the item before
  assign pop = q_valid && ((state == ST_IDLE) || advance);

  assign total_next = total + COUNT_W'(clm && (tally_new == '0));

  always_comb begin
    slot_we = 1'b0;
    slot_wa = SAW'(q_item.slot);
    slot_wd = q_item.value;
    if (clearing) begin
      slot_we = (32'(clr_addr) < 32'(SLOTS));
      slot_wa = SAW'(clr_addr);
      slot_wd = '0;
    end else if (pop && q_item.ok) begin
      slot_we = 1'b1;
    end
  end

  always_comb begin
    tally_we = 1'b0;
    tally_wa = VAW'(slot_rd);
    tally_wd = tally_old - COUNT_W'(1);
    case (state)
      ST_CLEAR: begin
        tally_we = (32'(clr_addr) < 32'(VALUES));
        tally_wa = VAW'(clr_addr);
        tally_wd = '0;
      end
      ST_WR_OLD: begin
        tally_we = rel && (tally_old != '0);
      end
      ST_WR_NEW: begin
        tally_we = advance && clm;
        tally_wa = VAW'(cur.value);
        tally_wd = tally_new + COUNT_W'(1);
      end
      default: begin
        tally_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CAW'(CLR_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_next = ST_TALLY;
        end
      end
      ST_TALLY:  state_next = ST_WR_OLD;
      ST_WR_OLD: state_next = ST_WR_NEW;
      ST_WR_NEW: begin
        if (advance) begin
          state_next = pop ? ST_TALLY : ST_IDLE;
        end
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  // read-first: a slot read and its rewrite share one cycle
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (pop) begin
      slot_rd <= slot_mem[SAW'(q_item.slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (tally_we) begin
      tally_mem[tally_wa] <= tally_wd;
    end
    if (state == ST_TALLY) begin
      tally_old <= tally_mem[VAW'(slot_rd)];
      tally_new <= tally_mem[VAW'(cur.value)];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
    if (state == ST_TALLY) begin
      // same value again leaves both tallies as they are
      rel <= cur.ok && (slot_rd != '0) && (slot_rd != cur.value);
      clm <= cur.ok && (cur.value != '0) && (slot_rd != cur.value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + CAW'(1);
      end
      if (state == ST_WR_OLD && rel && tally_old == COUNT_W'(1) && total != '0) begin
        total <= total - COUNT_W'(1);
      end else if (advance) begin
        total <= total_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_count <= total_next;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for distinct_value_tracker_top: slot assignments in,
// distinct value counts out, checked beat by beat against a local tally model
// depends on dvt_pkg and the design files under design/
module testbench;
  import dvt_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int VALUES      = VALUES_DEF;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  // covers the clearing pass after reset plus long random stalls
  localparam int STALL_LIMIT = 4 * (SLOTS > VALUES ? SLOTS : VALUES) + 1000;
  localparam int DRAIN_WAIT  = 16;
  localparam int PHASE_ITEMS = 130;
  localparam int MAX_PRINTS  = 30;
  localparam int N_DIRECTED  = 20;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               typed;   // count below is known by inspection
    logic [COUNT_W-1:0] count;
  } assign_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // local copy of the block state
  logic [VALUE_W-1:0] held_value [SLOTS];
  int unsigned        holders    [VALUES];
  int unsigned        distinct_now;
  int unsigned        peak_count;

  logic [COUNT_W-1:0] expected_counts [$];
  int errors;
  int items_sent;
  int counts_checked;
  int quiet_cycles;
  int tx_idle_pct;
  int rx_idle_pct;

  // slot_index, new_value, typed, count
  assign_row_t directed_rows [N_DIRECTED] = '{
    '{10'd0,     10'd1023,  1'b1, 11'd1},  // first assignment after reset
    '{10'd1023,  10'd1,     1'b1, 11'd2},
    '{10'd1023,  10'd1,     1'b1, 11'd2},  // same value again
    '{10'd0,     10'd1,     1'b1, 11'd1},  // old value released to zero
    '{10'd512,   10'd1,     1'b1, 11'd1},
    '{10'd0,     10'd0,     1'b1, 11'd1},  // zero value unassigns the slot
    '{10'd1023,  10'd0,     1'b1, 11'd1},
    '{10'd512,   10'd0,     1'b1, 11'd0},
    '{10'd7,     10'd0,     1'b1, 11'd0},  // zero on a slot never assigned
    '{10'h155,   10'h2aa,   1'b1, 11'd1},
    '{10'h2aa,   10'h155,   1'b1, 11'd2},
    '{10'h155,   10'h155,   1'b1, 11'd1},
    '{10'h3ff,   10'h3ff,   1'b0, 11'd0},
    '{10'd1,     10'h3ff,   1'b0, 11'd0},
    '{10'd2,     10'h200,   1'b0, 11'd0},
    '{10'd3,     10'h100,   1'b0, 11'd0},
    '{10'h200,   10'd1,     1'b0, 11'd0},
    '{10'h3fe,   10'h3fe,   1'b0, 11'd0},
    '{10'd1,     10'd0,     1'b0, 11'd0},
    '{10'h3ff,   10'h200,   1'b0, 11'd0}
  };
  // slots and values out of range, and a saturated count, cannot be
  // expressed at the default table sizes

  distinct_value_tracker_top #(
    .SLOTS  (SLOTS),
    .VALUES (VALUES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (errors < MAX_PRINTS) begin
      $display("error: %s", msg);
    end
    errors++;
  endtask

  // updates the local tables for one assignment, returns the new count
  function automatic logic [COUNT_W-1:0] apply_assignment(
    input logic [SLOT_W-1:0]  slot,
    input logic [VALUE_W-1:0] value
  );
    logic [VALUE_W-1:0] old;
    if (slot < SLOTS && value < VALUES) begin
      old = held_value[slot];
      if (old != '0 && holders[old] != 0) begin
        holders[old]--;
        if (holders[old] == 0 && distinct_now != 0) begin
          distinct_now--;
        end
      end
      if (value != '0) begin
        if (holders[value] == 0) begin
          distinct_now++;
        end
        holders[value]++;
      end
      held_value[slot] = value;
    end
    if (distinct_now > peak_count) begin
      peak_count = distinct_now;
    end
    return (distinct_now > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : distinct_now[COUNT_W-1:0];
  endfunction

  task automatic send_assignment(
    input logic [SLOT_W-1:0]  slot,
    input logic [VALUE_W-1:0] value,
    input logic               typed,
    input logic [COUNT_W-1:0] typed_count
  );
    logic [COUNT_W-1:0] predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - SLOT_W - VALUE_W){1'b0}}, value, slot};
    do begin
      @(posedge clk);
    end while (!s_tready);
    predicted = apply_assignment(slot, value);
    expected_counts.insert(expected_counts.size(), typed ? typed_count : predicted);
    items_sent++;
  endtask

  task automatic send_random_run(input int n_items);
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    int pick;
    repeat (n_items) begin
      // mostly a crowded corner of the tables so tallies rise and fall
      slot = ($urandom_range(99) < 85) ? SLOT_W'($urandom_range(31)) : SLOT_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 8) begin
        value = '0;
      end else if (pick < 88) begin
        value = VALUE_W'($urandom_range(15, 1));
      end else begin
        value = VALUE_W'($urandom);
      end
      send_assignment(slot, value, 1'b0, '0);
    end
  endtask

  // receiver: random backpressure and result checking
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_counts.size() == 0) begin
        report_error($sformatf("count %0d with no assignment pending",
                               m_tdata[COUNT_W-1:0]));
      end else begin
        if (m_tdata[COUNT_W-1:0] != expected_counts[0]) begin
          report_error($sformatf("distinct_count %0d, expected %0d",
                                 m_tdata[COUNT_W-1:0], expected_counts[0]));
        end
        if (m_tdata[OUT_TDATA_W-1:COUNT_W] != '0) begin
          report_error($sformatf("padding bits of m_tdata set: %h", m_tdata));
        end
        expected_counts.pop_front();
        counts_checked++;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("error: no beat for %0d cycles", STALL_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors         = 0;
    items_sent     = 0;
    counts_checked = 0;
    quiet_cycles   = 0;
    distinct_now   = 0;
    peak_count     = 0;
    tx_idle_pct    = 31;
    rx_idle_pct    = 46;
    for (int i = 0; i < SLOTS; i++) begin
      held_value[i] = '0;
    end
    for (int i = 0; i < VALUES; i++) begin
      holders[i] = 0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_assignment(directed_rows[i].slot, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].count);
    end
    send_random_run(PHASE_ITEMS);

    tx_idle_pct = 46;
    rx_idle_pct = 31;
    send_random_run(PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_run(PHASE_ITEMS);
    s_tvalid <= 1'b0;

    while (expected_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d assignments (%0d directed), checked %0d counts, %0d mismatches",
             items_sent, N_DIRECTED, counts_checked, errors);
    $display("highest distinct count reached: %0d", peak_count);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
